FILE: sv/cts_pkg.sv
// Package for the cycle timestamp splitter: state type and fixed constants.
`default_nettype none

package cts_pkg;

  localparam int unsigned CountW   = 6;
  localparam int unsigned ClockW   = 10;
  localparam int unsigned HzW      = 30;
  localparam int unsigned TpmW     = 20;
  localparam int unsigned SecondsW = 45;

  localparam logic [ClockW-1:0]  ClockReset     = 10'd168;
  localparam logic [HzW-1:0]     MicrosPerSec   = 30'd1000000;
  localparam logic [TpmW-1:0]    MicrosPerMilli = 20'd1000;
  localparam logic [CountW-1:0]  SecLast        = 6'd63;
  localparam logic [CountW-1:0]  FracLast       = 6'd9;
  localparam logic               RegClockMhz    = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StDivSec,
    StDivMs,
    StDivUs,
    StDone
  } cts_state_e;

endpackage

`default_nettype wire

FILE: sv/cycle_timestamp_splitter_unit.sv
// Top level: extends cycle counter samples and splits them into s / ms / us.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | counter_sample_i
//   out     | output    | out_valid_o / out_stall_i| extended_cycles_o, whole_seconds_o,
//           |           |                         | milli_part_o, micro_part_o,
//           |           |                         | total_micros_o
//   cfg     | input     | APB (psel/penable/...)  | clock_mhz at byte address 0
//
// Each request runs a bit-serial divide of the extended count by the clock in Hz
// (a divide by the clock in MHz runs beside it and yields total microseconds),
// then bit-serial divides for milliseconds and microseconds. The input stalls
// until a request's result has moved into the output register; a finished
// result waits in the output register, so the next request can enter while it
// is held. Reset clears wrap state and loads clock_mhz with 168.
`default_nettype none

module cycle_timestamp_splitter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [31:0]                   counter_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [63:0]                        extended_cycles_o,
  output logic [cts_pkg::SecondsW-1:0]       whole_seconds_o,
  output logic [cts_pkg::ClockW-1:0]         milli_part_o,
  output logic [cts_pkg::ClockW-1:0]         micro_part_o,
  output logic [63:0]                        total_micros_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cts_pkg::*;

  cts_state_e        state_q, state_d;
  logic [CountW-1:0] cnt_q;
  logic [ClockW-1:0] clock_mhz_q;
  logic [31:0]       prev_q, wrap_q;
  logic [31:0]       wrap_d;
  logic [63:0]       ext_q, acc_q, tot_q, ext_d;
  logic [HzW-1:0]    hz_q, rem_a_q, div_q;
  logic [TpmW-1:0]   tpm_q;
  logic [ClockW-1:0] mhz_q, rem_b_q, ms_q, us_q, mhz_eff;
  logic              out_valid_q;
  logic [63:0]       ext_out_q, tot_out_q;
  logic [SecondsW-1:0] sec_out_q;
  logic [ClockW-1:0] ms_out_q, us_out_q;

  logic              in_take, out_load, cfg_wr;
  logic [HzW:0]      rem_sh_a;
  logic              ge_a;
  logic [HzW-1:0]    rem_a_next;
  logic [ClockW:0]   rem_sh_b;
  logic              ge_b;
  logic [ClockW-1:0] rem_b_next;
  logic              ge_c;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegClockMhz);
  assign prdata = (paddr[2] == RegClockMhz) ? {22'd0, clock_mhz_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_mhz_q <= ClockReset;
    end else if (cfg_wr) begin
      clock_mhz_q <= pwdata[ClockW-1:0];
    end
  end

  assign mhz_eff = (clock_mhz_q == '0) ? ClockW'(1) : clock_mhz_q;

  // Wrap tracking
  assign in_take = in_valid_i && !in_stall_o;
  assign wrap_d  = (counter_sample_i < prev_q) ? wrap_q + 32'd1 : wrap_q;
  assign ext_d   = {wrap_d, counter_sample_i};

  // Seconds divide: one quotient bit per cycle
  assign rem_sh_a   = {rem_a_q, acc_q[63]};
  assign ge_a       = rem_sh_a >= {1'b0, hz_q};
  assign rem_a_next = ge_a ? HzW'(rem_sh_a - {1'b0, hz_q}) : rem_sh_a[HzW-1:0];

  // Microsecond total divide, fed by the same dividend bit
  assign rem_sh_b   = {rem_b_q, acc_q[63]};
  assign ge_b       = rem_sh_b >= {1'b0, mhz_q};
  assign rem_b_next = ge_b ? ClockW'(rem_sh_b - {1'b0, mhz_q}) : rem_sh_b[ClockW-1:0];

  // Fraction divides walk a pre-shifted divisor down one bit per cycle
  assign ge_c = rem_a_q >= div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = StDivSec;
        end
      end
      StDivSec: begin
        if (cnt_q == SecLast) begin
          state_d = StDivMs;
        end
      end
      StDivMs: begin
        if (cnt_q == FracLast) begin
          state_d = StDivUs;
        end
      end
      StDivUs: begin
        if (cnt_q == FracLast) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      wrap_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_take) begin
        prev_q <= counter_sample_i;
        wrap_q <= wrap_d;
        cnt_q  <= '0;
      end else if ((state_q == StDivSec && cnt_q == SecLast) ||
                   (state_q == StDivMs && cnt_q == FracLast) ||
                   (state_q == StDivUs && cnt_q == FracLast)) begin
        cnt_q <= '0;
      end else if (state_q == StDivSec || state_q == StDivMs || state_q == StDivUs) begin
        cnt_q <= cnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ext_q   <= ext_d;
      acc_q   <= ext_d;
      tot_q   <= '0;
      rem_a_q <= '0;
      rem_b_q <= '0;
      mhz_q   <= mhz_eff;
      hz_q    <= HzW'(HzW'(mhz_eff) * MicrosPerSec);
      tpm_q   <= TpmW'(TpmW'(mhz_eff) * MicrosPerMilli);
    end else begin
      case (state_q)
        StDivSec: begin
          acc_q   <= {acc_q[62:0], ge_a};
          tot_q   <= {tot_q[62:0], ge_b};
          rem_a_q <= rem_a_next;
          rem_b_q <= rem_b_next;
          if (cnt_q == SecLast) begin
            div_q <= HzW'({tpm_q, 9'd0});
          end
        end
        StDivMs: begin
          if (ge_c) begin
            rem_a_q <= rem_a_q - div_q;
          end
          ms_q <= {ms_q[ClockW-2:0], ge_c};
          if (cnt_q == FracLast) begin
            div_q <= HzW'({mhz_q, 9'd0});
          end else begin
            div_q <= div_q >> 1;
          end
        end
        StDivUs: begin
          if (ge_c) begin
            rem_a_q <= rem_a_q - div_q;
          end
          us_q  <= {us_q[ClockW-2:0], ge_c};
          div_q <= div_q >> 1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ext_out_q <= ext_q;
      sec_out_q <= acc_q[SecondsW-1:0];
      ms_out_q  <= ms_q;
      us_out_q  <= us_q;
      tot_out_q <= tot_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign extended_cycles_o = ext_out_q;
  assign whole_seconds_o   = sec_out_q;
  assign milli_part_o      = ms_out_q;
  assign micro_part_o      = us_out_q;
  assign total_micros_o    = tot_out_q;

endmodule

`default_nettype wire

FILE: tb/cts_stamp_checker.sv
// Checker for the cycle timestamp splitter: tracks wraps, predicts each split and compares.
module cts_stamp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [31:0]                  counter_sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [63:0]                  extended_cycles_i,
  input  logic [cts_pkg::SecondsW-1:0] whole_seconds_i,
  input  logic [cts_pkg::ClockW-1:0]   milli_part_i,
  input  logic [cts_pkg::ClockW-1:0]   micro_part_i,
  input  logic [63:0]                  total_micros_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [2:0]                   paddr_i,
  input  logic [31:0]                  pwdata_i,
  input  logic [31:0]                  prdata_i,
  input  logic                         pready_i,
  output int                           mismatches_o,
  output int                           stamps_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  localparam logic [2:0] ClockAddr = {RegClockMhz, 2'b00};
  localparam int         ReportMax = 10;

  typedef struct packed {
    logic [63:0]         ext;
    logic [SecondsW-1:0] secs;
    logic [ClockW-1:0]   ms;
    logic [ClockW-1:0]   us;
    logic [63:0]         total;
  } stamp_t;

  logic [ClockW-1:0] clock_mhz_q;
  logic [31:0]       last_sample_q;
  logic [31:0]       wrap_count_q;
  stamp_t            stamps_due[$];
  stamp_t            want;
  stamp_t            got;
  int                fail_count;

  function automatic stamp_t split_cycles(input logic [63:0] ext,
                                          input logic [ClockW-1:0] mhz_cfg);
    logic [63:0] mhz, hz, ticks_per_ms, secs, rest, ms, us;
    stamp_t      s;
    // a zero clock setting counts as 1 MHz
    mhz          = (mhz_cfg == '0) ? 64'd1 : 64'(mhz_cfg);
    hz           = mhz * 64'(MicrosPerSec);
    ticks_per_ms = mhz * 64'(MicrosPerMilli);
    secs         = ext / hz;
    rest         = ext - secs * hz;
    ms           = rest / ticks_per_ms;
    rest         = rest - ms * ticks_per_ms;
    us           = rest / mhz;
    s.ext        = ext;
    s.secs       = secs[SecondsW-1:0];
    s.ms         = ms[ClockW-1:0];
    s.us         = us[ClockW-1:0];
    s.total      = secs * 64'(MicrosPerSec) + ms * 64'(MicrosPerMilli) + us;
    return s;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= ReportMax) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_mhz_q   = ClockReset;
      last_sample_q = '0;
      wrap_count_q  = '0;
      fail_count    = 0;
      stamps_due.delete();
      mismatches_o     <= 0;
      stamps_pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ClockAddr) begin
        clock_mhz_q = pwdata_i[ClockW-1:0];
      end
      if (psel_i && penable_i && !pwrite_i && pready_i && paddr_i == ClockAddr &&
          prdata_i !== 32'(clock_mhz_q)) begin
        note_failure($sformatf("clock_mhz read: expected %0d, got %0d",
                               clock_mhz_q, prdata_i));
      end

      // retire the result before taking a new request at the same edge
      if (out_valid_i && !out_stall_i) begin
        got = '{extended_cycles_i, whole_seconds_i, milli_part_i, micro_part_i,
                total_micros_i};
        if (stamps_due.size() == 0) begin
          note_failure($sformatf("result with nothing pending: ext=%0d", got.ext));
        end else begin
          want = stamps_due.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"ext %0d/%0d secs %0d/%0d ms %0d/%0d us %0d/%0d ",
                                    "total %0d/%0d (expected/actual)"},
                                   want.ext, got.ext, want.secs, got.secs,
                                   want.ms, got.ms, want.us, got.us,
                                   want.total, got.total));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // a drop below the previous sample means the counter wrapped
        if (counter_sample_i < last_sample_q) wrap_count_q = wrap_count_q + 32'd1;
        last_sample_q = counter_sample_i;
        stamps_due.push_back(split_cycles({wrap_count_q, counter_sample_i}, clock_mhz_q));
      end

      mismatches_o     <= fail_count;
      stamps_pending_o <= stamps_due.size();
    end
  end

endmodule

FILE: tb/cycle_timestamp_splitter_unit_tb.sv
// Testbench top: drives counter samples and clock settings into the splitter, gives the verdict.
module cycle_timestamp_splitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  localparam logic [2:0] ClockAddr   = {RegClockMhz, 2'b00};
  localparam logic [2:0] SpareAddr   = {~RegClockMhz, 2'b00};
  localparam int         DrainCycles = 120;
  localparam int         NumPhases   = 8;
  localparam int         PhaseItems  = 185;
  localparam int         IdleMax     = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [31:0]         counter_sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [63:0]         extended_cycles_o;
  logic [SecondsW-1:0] whole_seconds_o;
  logic [ClockW-1:0]   milli_part_o;
  logic [ClockW-1:0]   micro_part_o;
  logic [63:0]         total_micros_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int          mismatches;
  int          stamps_pending;
  int unsigned gap_max   = IdleMax;
  int unsigned stall_max = IdleMax;

  cycle_timestamp_splitter_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .counter_sample_i,
    .out_valid_o, .out_stall_i, .extended_cycles_o, .whole_seconds_o,
    .milli_part_o, .micro_part_o, .total_micros_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cts_stamp_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i        (in_stall_o),
    .counter_sample_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .extended_cycles_i (extended_cycles_o),
    .whole_seconds_i   (whole_seconds_o),
    .milli_part_i      (milli_part_o),
    .micro_part_i      (micro_part_o),
    .total_micros_i    (total_micros_o),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .pready_i          (pready),
    .mismatches_o      (mismatches),
    .stamps_pending_o  (stamps_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Leaves valid high on return; the caller drops it after the last request.
  task automatic send_sample(input logic [31:0] sample);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    counter_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (stamps_pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_sample(input logic [31:0] last);
    logic [31:0] step;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    step = $urandom >> $urandom_range(0, 31);
    if (pick < 65) return last + step;
    else if (pick < 78) return $urandom;
    else if (pick < 84) return last;
    else if (pick < 90) return pick[0] ? 32'hFFFF_FFFF : 32'h0;
    else return last - step;
  endfunction

  function automatic logic [ClockW-1:0] phase_clock(input int p);
    case (p)
      0:       return 10'd1000;
      1:       return 10'd1;
      2:       return 10'd0;
      3:       return 10'd1023;
      4:       return 10'd1001;
      5:       return 10'd500;
      7:       return ClockReset;
      default: return ClockW'($urandom_range(1, 1023));
    endcase
  endfunction

  // Equal samples, full-range jumps and backward steps that count as wraps.
  logic [31:0] corner_samples [14] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005, 32'h0000_0004,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0000
  };

  initial begin
    logic [31:0] sample;
    logic [31:0] junk;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    counter_sample_i <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // read the reset clock setting first
    apb_access(1'b0, ClockAddr, '0);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    in_valid_i <= 1'b0;
    sample = corner_samples[13];

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      apb_access(1'b1, SpareAddr, $urandom);
      junk = $urandom;
      // upper write bits are junk and must be dropped
      apb_access(1'b1, ClockAddr, {junk[31:ClockW], phase_clock(p)});
      apb_access(1'b0, ClockAddr, '0);
      gap_max   = (p % 3 == 2) ? 0 : IdleMax;
      stall_max = (p % 4 == 1) ? 0 : IdleMax;
      repeat (PhaseItems) begin
        sample = next_sample(sample);
        send_sample(sample);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (mismatches == 0 && stamps_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: hold stall for a random count, then take one result.
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      hold = $urandom_range(0, stall_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

endmodule
